// ===== rtl/avd_pkg.sv =====
// Shared types, widths and constants of the airborne velocity decoder.
`default_nettype none

package avd_pkg;

   localparam int ME_W     = 56;
   localparam int RAW_W    = 10;
   localparam int SPEED_W  = 12;
   localparam int TRACK_W  = 9;
   localparam int VR_W     = 16;
   localparam int SQ_W     = 2 * RAW_W;
   localparam int MAG_W    = SQ_W + 1;
   localparam int XS_W     = 43;
   localparam int D_W      = 22;
   localparam int DSQ_W    = 2 * D_W;
   localparam int CX_W     = 34;
   localparam int CZ_W     = 29;
   localparam int ANG_FRAC = 20;
   localparam int ATAN_LEN = 24;

   // 1852 squared: km per nautical mile times 1000, squared
   localparam logic [XS_W-1:0] SPEED_SCALE_SQ = XS_W'(3429904);
   localparam logic [D_W-1:0]  SPEED_STEP     = D_W'(1000);
   localparam logic [D_W-1:0]  SPEED_HALF     = D_W'(500);

   localparam logic [CZ_W-1:0] ANG_RIGHT = CZ_W'(90  * (2 ** ANG_FRAC));
   localparam logic [CZ_W-1:0] ANG_HALF  = CZ_W'(180 * (2 ** ANG_FRAC));
   localparam logic [CZ_W-1:0] ANG_FULL  = CZ_W'(360 * (2 ** ANG_FRAC));

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_GROUND = 2'd1,
      KIND_AIR    = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic signed [VR_W-1:0]  vr;
      logic [TRACK_W-1:0]      track;
      logic [SPEED_W-1:0]      speed;
      logic [RAW_W-1:0]        ae;
      logic [RAW_W-1:0]        an;
      logic                    neg_e;
      logic                    neg_n;
      logic [SQ_W-1:0]         sq_e;
      logic [SQ_W-1:0]         sq_n;
      logic [XS_W-1:0]         xs;
      logic signed [CX_W-1:0]  cx;
      logic signed [CX_W-1:0]  cy;
      logic signed [CZ_W-1:0]  cz;
   } pipe_type;

   // atan(2^-i) in degrees, 20 fraction bits
   function automatic logic signed [CZ_W-1:0] atan_deg(input int idx);
      logic signed [CZ_W-1:0] r;
      case (idx)
         0:  r = CZ_W'(47185920);
         1:  r = CZ_W'(27855475);
         2:  r = CZ_W'(14718068);
         3:  r = CZ_W'(7471121);
         4:  r = CZ_W'(3750058);
         5:  r = CZ_W'(1876857);
         6:  r = CZ_W'(938658);
         7:  r = CZ_W'(469357);
         8:  r = CZ_W'(234682);
         9:  r = CZ_W'(117342);
         10: r = CZ_W'(58671);
         11: r = CZ_W'(29335);
         12: r = CZ_W'(14668);
         13: r = CZ_W'(7334);
         14: r = CZ_W'(3667);
         15: r = CZ_W'(1833);
         16: r = CZ_W'(917);
         17: r = CZ_W'(458);
         18: r = CZ_W'(229);
         19: r = CZ_W'(115);
         20: r = CZ_W'(57);
         21: r = CZ_W'(29);
         22: r = CZ_W'(14);
         23: r = CZ_W'(7);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/airborne_velocity_decoder.sv =====
// Top level: pipelined airborne velocity decoder with CORDIC track and speed search.
//
// Usage: one ME field enters on the req_ channel as a word; one result word
// leaves on the rsp_ channel for every accepted input, in order. Both channels
// use valid/stall; a word moves at a clock edge with valid high and stall low.
// The stages are decode, squaring, speed scaling, one stage per CORDIC
// iteration or speed bit, whichever are more (each also resolves one speed bit
// while the 12 speed bits last), then track rounding into the output register.
// Throughput is one word per cycle while rsp_stall is low; every stage holds a
// valid bit, and a stage accepts new data whenever it is empty or its successor
// moves, so bubbles collapse and the input keeps flowing while a result waits.
// When rsp_stall is held, the pipeline fills and then asserts req_stall.
// Synchronous reset empties every stage; no result is pending afterwards.
// There is no configuration and no state carried between messages.
`default_nettype none

module airborne_velocity_decoder #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [avd_pkg::ME_W-1:0]             req_me_field,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [avd_pkg::SPEED_W-1:0]               rsp_speed_kmh,
   output logic [avd_pkg::TRACK_W-1:0]               rsp_track_deg,
   output logic signed [avd_pkg::VR_W-1:0]           rsp_vertical_rate,
   output logic [1:0]                                rsp_velocity_kind
);

   localparam int ITERS = (ANGLE_ITERATIONS > avd_pkg::ATAN_LEN) ?
                          avd_pkg::ATAN_LEN : ANGLE_ITERATIONS;
   localparam int P     = (ITERS > avd_pkg::SPEED_W) ? ITERS : avd_pkg::SPEED_W;
   localparam int NS    = P + 4;
   localparam int RAW_W_L = avd_pkg::RAW_W;

   avd_pkg::pipe_type pipe_ff [NS];
   avd_pkg::pipe_type pipe_in [NS];
   logic [NS-1:0]     valid_ff;
   logic [NS-1:0]     rdy;

   // advance a stage when it is empty or its successor moves
   always_comb begin
      rdy[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign req_stall = !rdy[0];

   // decode the ME word
   always_comb begin
      logic [2:0]         sub;
      logic [RAW_W_L-1:0] raw_a;
      logic [RAW_W_L-1:0] raw_b;
      logic               ground;
      logic               air;
      logic signed [10:0] vstep;
      logic signed [10:0] vneg;
      logic [avd_pkg::VR_W-1:0] vr_ext;
      logic [15:0]        hd;
      logic [avd_pkg::TRACK_W-1:0] hq;
      logic [6:0]         hrem;
      logic               hinc;
      sub    = req_me_field[50:48];
      raw_a  = req_me_field[41:32];
      raw_b  = req_me_field[30:21];
      ground = (sub == 3'd1 || sub == 3'd2) && raw_a != '0 && raw_b != '0;
      air    = (sub == 3'd3 || sub == 3'd4);
      vstep  = $signed({2'b00, req_me_field[18:10]}) - 11'sd1;
      vneg   = req_me_field[19] ? -vstep : vstep;
      vr_ext = {{(avd_pkg::VR_W - 11){vneg[10]}}, vneg};
      hd     = 16'(raw_a) * 16'd45;
      hq     = hd[15:7];
      hrem   = hd[6:0];
      hinc   = (hrem > 7'd64) || (hrem == 7'd64 && hq[0]);

      pipe_in[0]       = '0;
      pipe_in[0].neg_e = req_me_field[42];
      pipe_in[0].neg_n = req_me_field[31];
      if (ground) begin
         pipe_in[0].kind = avd_pkg::KIND_GROUND;
         pipe_in[0].vr   = $signed(vr_ext << 6);
         pipe_in[0].ae   = raw_a - RAW_W_L'(1);
         pipe_in[0].an   = raw_b - RAW_W_L'(1);
      end else if (air) begin
         pipe_in[0].kind  = avd_pkg::KIND_AIR;
         pipe_in[0].vr    = $signed(vr_ext);
         pipe_in[0].track = hq + avd_pkg::TRACK_W'(hinc);
         pipe_in[0].an    = (raw_b == '0) ? '0 : raw_b - RAW_W_L'(1);
      end else begin
         pipe_in[0].kind = avd_pkg::KIND_NONE;
      end
      pipe_in[0].cx = $signed(avd_pkg::CX_W'(pipe_in[0].an) << avd_pkg::ANG_FRAC);
      pipe_in[0].cy = $signed(avd_pkg::CX_W'(pipe_in[0].ae) << avd_pkg::ANG_FRAC);
   end

   // square the components
   always_comb begin
      pipe_in[1]      = pipe_ff[0];
      pipe_in[1].sq_e = avd_pkg::SQ_W'(pipe_ff[0].ae) * avd_pkg::SQ_W'(pipe_ff[0].ae);
      pipe_in[1].sq_n = avd_pkg::SQ_W'(pipe_ff[0].an) * avd_pkg::SQ_W'(pipe_ff[0].an);
   end

   // scale the squared magnitude by 1852 squared
   always_comb begin
      logic [avd_pkg::MAG_W-1:0] mag;
      mag             = avd_pkg::MAG_W'(pipe_ff[1].sq_e) + avd_pkg::MAG_W'(pipe_ff[1].sq_n);
      pipe_in[2]       = pipe_ff[1];
      pipe_in[2].xs    = avd_pkg::XS_W'(mag) * avd_pkg::SPEED_SCALE_SQ;
      pipe_in[2].speed = '0;
   end

   // at most one CORDIC iteration and one speed bit per stage
   for (genvar k = 0; k < P; k++) begin : g_iter
      always_comb begin
         avd_pkg::pipe_type         s;
         logic [avd_pkg::SPEED_W-1:0] cand;
         logic [avd_pkg::D_W-1:0]     d;
         logic [avd_pkg::DSQ_W-1:0]   dsq;
         logic [avd_pkg::DSQ_W-1:0]   xw;
         logic                        ge;
         s    = pipe_ff[2+k];
         cand = '0;
         d    = '0;
         dsq  = '0;
         xw   = '0;
         ge   = 1'b0;
         pipe_in[3+k] = s;
         if (k < ITERS) begin
            if (!s.cy[avd_pkg::CX_W-1]) begin
               pipe_in[3+k].cx = s.cx + (s.cy >>> k);
               pipe_in[3+k].cy = s.cy - (s.cx >>> k);
               pipe_in[3+k].cz = s.cz + avd_pkg::atan_deg(k);
            end else begin
               pipe_in[3+k].cx = s.cx - (s.cy >>> k);
               pipe_in[3+k].cy = s.cy + (s.cx >>> k);
               pipe_in[3+k].cz = s.cz - avd_pkg::atan_deg(k);
            end
         end
         if (k < avd_pkg::SPEED_W) begin
            cand = s.speed | (avd_pkg::SPEED_W'(1) << (avd_pkg::SPEED_W - 1 - k));
            d    = avd_pkg::D_W'(cand) * avd_pkg::SPEED_STEP - avd_pkg::SPEED_HALF;
            dsq  = avd_pkg::DSQ_W'(d) * avd_pkg::DSQ_W'(d);
            xw   = avd_pkg::DSQ_W'(s.xs);
            ge   = (xw > dsq) || (xw == dsq && !cand[0]);
            if (ge) begin
               pipe_in[3+k].speed = cand;
            end
         end
      end
   end

   // map quadrant, round track and pick fields by kind
   always_comb begin
      avd_pkg::pipe_type        s;
      logic [avd_pkg::CZ_W-1:0] a;
      logic [avd_pkg::CZ_W-1:0] ang;
      logic                     ve_neg;
      logic                     vn_neg;
      logic [avd_pkg::TRACK_W-1:0] q;
      logic [avd_pkg::ANG_FRAC-1:0] rem;
      logic                     inc;
      logic [avd_pkg::TRACK_W-1:0] gtrack;
      s = pipe_ff[NS-2];
      if (s.cz[avd_pkg::CZ_W-1]) begin
         a = '0;
      end else if (avd_pkg::CZ_W'(s.cz) > avd_pkg::ANG_RIGHT) begin
         a = avd_pkg::ANG_RIGHT;
      end else begin
         a = avd_pkg::CZ_W'(s.cz);
      end
      ve_neg = s.neg_e && s.ae != '0;
      vn_neg = s.neg_n && s.an != '0;
      if (!vn_neg && !ve_neg) begin
         ang = a;
      end else if (vn_neg && !ve_neg) begin
         ang = avd_pkg::ANG_HALF - a;
      end else if (vn_neg) begin
         ang = avd_pkg::ANG_HALF + a;
      end else begin
         ang = avd_pkg::ANG_FULL - a;
      end
      q   = ang[avd_pkg::CZ_W-1:avd_pkg::ANG_FRAC];
      rem = ang[avd_pkg::ANG_FRAC-1:0];
      inc = (rem > {1'b1, {(avd_pkg::ANG_FRAC-1){1'b0}}}) ||
            (rem == {1'b1, {(avd_pkg::ANG_FRAC-1){1'b0}}} && q[0]);
      gtrack = (s.ae == '0 && s.an == '0) ? '0 : q + avd_pkg::TRACK_W'(inc);
      pipe_in[NS-1] = s;
      case (s.kind)
         avd_pkg::KIND_GROUND: pipe_in[NS-1].track = gtrack;
         avd_pkg::KIND_AIR:    pipe_in[NS-1].track = s.track;
         default:              pipe_in[NS-1].track = '0;
      endcase
   end

   // advance valid bits and stage data
   for (genvar i = 0; i < NS; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            valid_ff[i] <= (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign rsp_valid         = valid_ff[NS-1];
   assign rsp_speed_kmh     = pipe_ff[NS-1].speed;
   assign rsp_track_deg     = pipe_ff[NS-1].track;
   assign rsp_vertical_rate = pipe_ff[NS-1].vr;
   assign rsp_velocity_kind = pipe_ff[NS-1].kind;

endmodule

`default_nettype wire
